FILE: sv/fm_pkg.sv
`timescale 1ns / 1ps

package fm_pkg;

    // Item opcode: a new command request or one received reply byte.
    typedef enum logic {
        OP_REQUEST = 1'b0,
        OP_RX_BYTE = 1'b1
    } t_op;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_VERSION    = 2'd0,
        CMD_SET_CONFIG = 2'd1,
        CMD_SET_OUTPUT = 2'd2,
        CMD_GET_INPUT  = 2'd3
    } t_cmd;

    // Result kind.
    typedef enum logic {
        KIND_TX      = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    // Verdict status codes.
    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_NO_CR    = 2'd2
    } t_status;

    // Characters used in frames.
    localparam logic [7:0] CHR_CR      = 8'h0D;
    localparam logic [7:0] CHR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHR_PERCENT = 8'h25;
    localparam logic [7:0] CHR_AT      = 8'h40;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_F       = 8'h46;

    // Fixed tail of the set configuration command.
    localparam logic [7:0] CONFIG_TAIL [0:7] = '{
        8'h30, 8'h31, 8'h34, 8'h30, 8'h30, 8'h41, 8'h34, 8'h31
    };

    // Input beat payload.
    typedef struct packed {
        t_op        op;
        t_cmd       command;
        logic [3:0] module_address;
        logic [3:0] output_value;
        logic [7:0] rx_byte;
    } t_in_beat;

    // Output beat payload.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic        last;
        t_status     status;
        logic [15:0] input_word;
    } t_out_beat;

    // Transmit byte offered by the frame emitter.
    typedef struct packed {
        logic       valid;
        logic [7:0] tx_byte;
        logic       last;
    } t_emit;

    // Verdict offered by the reply checker.
    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [15:0] input_word;
    } t_verdict;

    // Upper-case hex character for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] w;
        w = {4'b0000, v};
        return (v < 4'd10) ? (CHR_ZERO + w) : (w + 8'h37);
    endfunction

    // Hex character decode: bit 4 set when the byte is a valid digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        return 5'b00000;
    endfunction

    // Total frame length including checksum digits and CR.
    function automatic logic [3:0] frame_len(input t_cmd cmd);
        case (cmd)
            CMD_VERSION:    return 4'd7;
            CMD_SET_CONFIG: return 4'd14;
            CMD_SET_OUTPUT: return 4'd7;
            default:        return 4'd6;
        endcase
    endfunction

    // Expected reply length.
    function automatic logic [3:0] reply_len(input t_cmd cmd);
        case (cmd)
            CMD_VERSION:    return 4'd9;
            CMD_SET_CONFIG: return 4'd6;
            CMD_SET_OUTPUT: return 4'd4;
            default:        return 4'd8;
        endcase
    endfunction

    // Sum of the fixed characters of a frame, modulo 256.
    function automatic logic [7:0] frame_sum_base(input t_cmd cmd);
        case (cmd)
            CMD_VERSION:    return 8'h9A;
            CMD_SET_CONFIG: return 8'hF0;
            default:        return 8'h70;
        endcase
    endfunction

endpackage

FILE: sv/fm_in_if.sv
`timescale 1ns / 1ps

interface fm_in_if import fm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/fm_out_if.sv
`timescale 1ns / 1ps

interface fm_out_if import fm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/fm_emitter.sv
`timescale 1ns / 1ps

module fm_emitter import fm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_beat i_beat,
    input  logic     i_adv,
    output t_emit    o_emit
);

    logic       r_active;
    t_cmd       r_cmd;
    logic [7:0] r_a;
    logic [7:0] r_d;
    logic [7:0] r_sum;
    logic [3:0] r_idx;
    logic [3:0] r_len;

    logic [7:0] start_a;
    logic [7:0] start_d;
    logic [7:0] start_sum;
    logic [3:0] body_len;
    logic [3:0] tail_idx;
    logic [7:0] cur_byte;
    logic       cur_last;

    // Address and data digits and the frame checksum at request time.
    always_comb begin
        start_a   = CHR_ZERO + {4'b0000, i_beat.module_address};
        start_d   = CHR_ZERO + {4'b0000, i_beat.output_value};
        start_sum = frame_sum_base(i_beat.command) + start_a
                    + ((i_beat.command == CMD_SET_OUTPUT) ? start_d : 8'h00);
    end

    // Byte at the current frame position.
    always_comb begin
        body_len = r_len - 4'd3;
        tail_idx = r_idx - 4'd3;
        cur_last = (r_idx == (r_len - 4'd1));
        if (r_idx < body_len) begin
            case (r_idx)
                4'd0: begin
                    case (r_cmd)
                        CMD_VERSION:    cur_byte = CHR_DOLLAR;
                        CMD_SET_CONFIG: cur_byte = CHR_PERCENT;
                        default:        cur_byte = CHR_AT;
                    endcase
                end
                4'd1: cur_byte = CHR_ZERO;
                4'd2: cur_byte = r_a;
                default: begin
                    case (r_cmd)
                        CMD_SET_CONFIG: cur_byte = CONFIG_TAIL[tail_idx[2:0]];
                        CMD_SET_OUTPUT: cur_byte = r_d;
                        default:        cur_byte = CHR_F;
                    endcase
                end
            endcase
        end else if (r_idx == body_len) begin
            cur_byte = hex_digit(r_sum[7:4]);
        end else if (r_idx == (body_len + 4'd1)) begin
            cur_byte = hex_digit(r_sum[3:0]);
        end else begin
            cur_byte = CHR_CR;
        end
    end

    // Frame sequencer: one byte per beat taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= 4'd0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_idx    <= 4'd0;
        end else if (r_active && i_adv) begin
            r_idx <= r_idx + 4'd1;
            if (cur_last) begin
                r_active <= 1'b0;
            end
        end
    end

    // Frame contents, captured with the request.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cmd <= i_beat.command;
            r_a   <= start_a;
            r_d   <= start_d;
            r_sum <= start_sum;
            r_len <= frame_len(i_beat.command);
        end
    end

    assign o_emit.valid   = r_active;
    assign o_emit.tx_byte = cur_byte;
    assign o_emit.last    = cur_last;

endmodule

FILE: sv/fm_checker.sv
`timescale 1ns / 1ps

module fm_checker import fm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req,
    input  logic     i_rsp,
    input  t_in_beat i_beat,
    input  logic     i_take,
    output t_verdict o_vd
);

    logic        r_await;
    t_cmd        r_cmd;
    logic [3:0]  r_exp;
    logic [3:0]  r_count;
    logic [7:0]  r_sum;
    logic [3:0]  r_hi;
    logic        r_bad;
    logic [15:0] r_value;
    logic        r_vd_valid;
    t_status     r_vd_status;
    logic [15:0] r_vd_word;

    logic        n_await;
    logic [3:0]  n_count;
    logic [7:0]  n_sum;
    logic [3:0]  n_hi;
    logic        n_bad;
    logic [15:0] n_value;
    logic        fin;
    t_status     fin_status;
    logic [15:0] fin_word;
    logic [4:0]  idx5;
    logic [4:0]  exp5;
    logic [4:0]  hv;

    // Reply byte bookkeeping.
    always_comb begin
        n_await    = r_await;
        n_count    = r_count;
        n_sum      = r_sum;
        n_hi       = r_hi;
        n_bad      = r_bad;
        n_value    = r_value;
        fin        = 1'b0;
        fin_status = ST_GOOD;
        fin_word   = 16'h0000;
        idx5       = {1'b0, r_count};
        exp5       = {1'b0, r_exp};
        hv         = hex_value(i_beat.rx_byte);
        if (i_rsp && r_await) begin
            if ((idx5 + 5'd1) >= exp5) begin
                // Final byte: give the verdict.
                fin = 1'b1;
                if (r_bad) begin
                    fin_status = ST_CHECKSUM;
                end else if (i_beat.rx_byte != CHR_CR) begin
                    fin_status = ST_NO_CR;
                end
                if (fin_status == ST_GOOD && r_cmd == CMD_GET_INPUT) begin
                    fin_word = r_value;
                end
                n_await = 1'b0;
                n_count = 4'd0;
            end else begin
                if ((idx5 + 5'd3) < exp5) begin
                    // Body byte: sum it, and collect value digits for input reads.
                    n_sum = r_sum + i_beat.rx_byte;
                    if (r_cmd == CMD_GET_INPUT && r_count >= 4'd1 && r_count <= 4'd4) begin
                        if (!hv[4]) begin
                            n_bad = 1'b1;
                        end else begin
                            n_value = {r_value[11:0], hv[3:0]};
                        end
                    end
                end else if ((idx5 + 5'd3) == exp5) begin
                    // High checksum digit.
                    if (!hv[4]) begin
                        n_bad = 1'b1;
                    end else begin
                        n_hi = hv[3:0];
                    end
                end else begin
                    // Low checksum digit: compare with the running sum.
                    if (!hv[4] || ({r_hi, hv[3:0]} != r_sum)) begin
                        n_bad = 1'b1;
                    end
                end
                n_count = r_count + 4'd1;
            end
        end
    end

    // Reply state and verdict register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await    <= 1'b0;
            r_cmd      <= CMD_VERSION;
            r_exp      <= 4'd0;
            r_count    <= 4'd0;
            r_sum      <= 8'h00;
            r_hi       <= 4'd0;
            r_bad      <= 1'b0;
            r_value    <= 16'h0000;
            r_vd_valid <= 1'b0;
        end else begin
            if (i_req) begin
                r_await <= 1'b1;
                r_cmd   <= i_beat.command;
                r_exp   <= reply_len(i_beat.command);
                r_count <= 4'd0;
                r_sum   <= 8'h00;
                r_hi    <= 4'd0;
                r_bad   <= 1'b0;
                r_value <= 16'h0000;
            end else begin
                r_await <= n_await;
                r_count <= n_count;
                r_sum   <= n_sum;
                r_hi    <= n_hi;
                r_bad   <= n_bad;
                r_value <= n_value;
            end
            if (fin) begin
                r_vd_valid <= 1'b1;
            end else if (i_take) begin
                r_vd_valid <= 1'b0;
            end
        end
    end

    // Verdict payload.
    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_vd_status <= fin_status;
            r_vd_word   <= fin_word;
        end
    end

    assign o_vd.valid      = r_vd_valid;
    assign o_vd.status     = r_vd_status;
    assign o_vd.input_word = r_vd_word;

    // A verdict is never built while the previous one is still held.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> (!r_vd_valid || i_take))
        else $error("verdict overwritten before it was taken");

    // Input words appear only in good verdicts.
    a_word_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && fin_status != ST_GOOD) |=> (r_vd_word == 16'h0000))
        else $error("input word in a failed verdict");

    // The count never reaches the expected length while a reply is awaited.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> (r_count < r_exp))
        else $error("reply count out of range");

endmodule

FILE: sv/ascii_io_module_frame_master_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Modport  Payload
// i_in      in   sink     op, command, module_address, output_value, rx_byte
// o_out     out  source   kind, tx_byte, last, status, input_word
//
// A reply byte is taken in every cycle; its verdict, if any, goes through the checker's
// verdict register and the output register to o_out. A request holds i_in.ready low while
// its frame goes out: 6, 7 or 14 beats, one per cycle from the frame sequencer, starting
// the cycle after the request is taken. Synchronous active-low reset returns the block to
// the no-reply-awaited state. A stall on o_out backs up through the output register into
// the sequencer and, while a verdict waits, into i_in.ready.

module ascii_io_module_frame_master_unit import fm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    fm_in_if.sink    i_in,
    fm_out_if.source o_out
);

    logic      r_out_valid;
    t_out_beat r_out;

    t_emit     emit;
    t_verdict  vd;
    logic      out_load;
    logic      in_acc;
    logic      req_acc;
    logic      rsp_acc;
    logic      vd_take;

    // Handshake steering.
    assign out_load   = !r_out_valid || o_out.ready;
    assign vd_take    = out_load && !emit.valid && vd.valid;
    assign i_in.ready = !emit.valid && (!vd.valid || out_load);
    assign in_acc     = i_in.valid && i_in.ready;
    assign req_acc    = in_acc && (i_in.data.op == OP_REQUEST);
    assign rsp_acc    = in_acc && (i_in.data.op == OP_RX_BYTE);

    fm_emitter u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (req_acc),
        .i_beat  (i_in.data),
        .i_adv   (out_load),
        .o_emit  (emit)
    );

    fm_checker u_checker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_acc),
        .i_rsp   (rsp_acc),
        .i_beat  (i_in.data),
        .i_take  (vd_take),
        .o_vd    (vd)
    );

    // Output register: frame bytes first, then any waiting verdict.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= emit.valid || vd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (emit.valid) begin
                r_out.kind       <= KIND_TX;
                r_out.tx_byte    <= emit.tx_byte;
                r_out.last       <= emit.last;
                r_out.status     <= ST_GOOD;
                r_out.input_word <= 16'h0000;
            end else begin
                r_out.kind       <= KIND_VERDICT;
                r_out.tx_byte    <= 8'h00;
                r_out.last       <= 1'b1;
                r_out.status     <= vd.status;
                r_out.input_word <= vd.input_word;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // No input beat is taken while a frame is going out.
    a_frame_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.valid |-> !in_acc)
        else $error("input taken during frame emission");

    // A taken request starts its frame on the next cycle.
    a_req_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> emit.valid)
        else $error("frame did not start after request");

    // Verdict beats always close with last and carry no transmit byte.
    a_verdict_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_VERDICT) |-> (r_out.last && r_out.tx_byte == 8'h00))
        else $error("malformed verdict beat");

endmodule
